[design/dsst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor-sum sieve table package
// Shared widths, datapath command codes and the status bundle that the
// controller and datapath exchange.
// ----------------------------------------------------------------------------
package dsst_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LIMIT_W     = 14;
    localparam int SUM_W       = 17;
    localparam int LIMIT_RESET = 16383;
    localparam int DCNT_W      = $clog2(ADDR_W + 1);

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CLR,
        CMD_SV_INIT,
        CMD_SV_RD,
        CMD_SV_NEXT,
        CMD_SV_JINIT,
        CMD_SV_MARK,
        CMD_FL_INIT,
        CMD_FL_SMALL,
        CMD_FL_RD,
        CMD_FL_PRIME,
        CMD_FL_START,
        CMD_DIV_STEP,
        CMD_FL_MUL,
        CMD_FL_ACC,
        CMD_FL_RDS,
        CMD_FL_PROD,
        CMD_FL_WR,
        CMD_BUILD_END,
        CMD_Q_RD,
        CMD_Q_CHK,
        CMD_Q_FIN,
        CMD_Q_OOR
    } t_cmd;

    typedef struct packed {
        logic in_build;
        logic clr_last;
        logic sq_over;
        logic fac_zero;
        logic j_over;
        logic fill_over;
        logic i_small;
        logic div_done;
        logic rem_zero;
        logic q_oor;
        logic out_free;
    } t_status;

endpackage

[design/divisor_sum_sieve_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor-sum sieve table
// Builds a prime-factor sieve and a table of divisor sums, then answers
// queries for proper-divisor sum, primality and amicability of one number.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid / o_in_stall       i_func, i_number
//   out      output     o_out_valid / i_out_stall     sum, prime, amicable,
//                                                     out of range, build done
//   config   input      psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// A query runs through its read, check and finish states before the next
// transfer is accepted; its second single-port sum read needs the first.
// A build of limit L clears factor entries 0..L, sieves with each prime
// whose square does not exceed L, marking its multiples, then fills the sum
// of every number up to L: a composite has a prime factor divided out one
// quotient bit per step, and its prime-power sum times the cofactor's entry
// is written. The tables need no clearing pass after reset.
// Reset is synchronous and active low; the limit register resets to 16383.
// A stalled result sits in the output register; the block goes back to idle
// and takes the next item, then waits before loading a new result.
// ----------------------------------------------------------------------------
module divisor_sum_sieve_table import dsst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [LIMIT_W-1:0] i_number,
    // Result output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SUM_W-1:0]   o_proper_divisor_sum,
    output logic               o_is_prime,
    output logic               o_is_amicable,
    output logic               o_out_of_range,
    output logic               o_build_done,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] r_table_limit;
    t_status            w_status;
    t_cmd               w_cmd;

    // The only register answers at any address whose upper bit is clear; an
    // address with it set selects nothing: writes are dropped, reads give zero.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_limit <= LIMIT_W'(LIMIT_RESET);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_table_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_table_limit);

    // The controller walks the build and query sequences; the datapath
    // holds the tables, counters, divider and result register.
    dsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    dsst_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_func               (i_func),
        .i_number             (i_number),
        .i_table_limit        (r_table_limit),
        .i_out_stall          (i_out_stall),
        .o_status             (w_status),
        .o_out_valid          (o_out_valid),
        .o_proper_divisor_sum (o_proper_divisor_sum),
        .o_is_prime           (o_is_prime),
        .o_is_amicable        (o_is_amicable),
        .o_out_of_range       (o_out_of_range),
        .o_build_done         (o_build_done)
    );

endmodule

[design/dsst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor-sum sieve table controller
// Sequences table builds and queries by issuing one command per cycle.
// ----------------------------------------------------------------------------
module dsst_ctrl import dsst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [16:0] {
        ST_IDLE      = 17'h00001,
        ST_CLR       = 17'h00002,
        ST_SV_INIT   = 17'h00004,
        ST_SV_RD     = 17'h00008,
        ST_SV_TST    = 17'h00010,
        ST_SV_MARK   = 17'h00020,
        ST_FL_RD     = 17'h00040,
        ST_FL_TST    = 17'h00080,
        ST_FL_DIV    = 17'h00100,
        ST_FL_ACC    = 17'h00200,
        ST_FL_PRD    = 17'h00400,
        ST_FL_WR     = 17'h00800,
        ST_BUILD_END = 17'h01000,
        ST_Q_START   = 17'h02000,
        ST_Q_CHK     = 17'h04000,
        ST_Q_FIN     = 17'h08000,
        ST_Q_OOR     = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_ACCEPT;
                    n_state = i_status.in_build ? ST_CLR : ST_Q_START;
                end
            end
            ST_CLR: begin
                o_cmd = CMD_CLR;
                if (i_status.clr_last) begin
                    n_state = ST_SV_INIT;
                end
            end
            ST_SV_INIT: begin
                o_cmd   = CMD_SV_INIT;
                n_state = ST_SV_RD;
            end
            ST_SV_RD: begin
                if (i_status.sq_over) begin
                    o_cmd   = CMD_FL_INIT;
                    n_state = ST_FL_RD;
                end else begin
                    o_cmd   = CMD_SV_RD;
                    n_state = ST_SV_TST;
                end
            end
            ST_SV_TST: begin
                if (i_status.fac_zero) begin
                    o_cmd   = CMD_SV_JINIT;
                    n_state = ST_SV_MARK;
                end else begin
                    o_cmd   = CMD_SV_NEXT;
                    n_state = ST_SV_RD;
                end
            end
            ST_SV_MARK: begin
                if (i_status.j_over) begin
                    o_cmd   = CMD_SV_NEXT;
                    n_state = ST_SV_RD;
                end else begin
                    o_cmd = CMD_SV_MARK;
                end
            end
            ST_FL_RD: begin
                if (i_status.fill_over) begin
                    n_state = ST_BUILD_END;
                end else if (i_status.i_small) begin
                    o_cmd = CMD_FL_SMALL;
                end else begin
                    o_cmd   = CMD_FL_RD;
                    n_state = ST_FL_TST;
                end
            end
            ST_FL_TST: begin
                if (i_status.fac_zero) begin
                    o_cmd   = CMD_FL_PRIME;
                    n_state = ST_FL_RD;
                end else begin
                    o_cmd   = CMD_FL_START;
                    n_state = ST_FL_DIV;
                end
            end
            ST_FL_DIV: begin
                if (!i_status.div_done) begin
                    o_cmd = CMD_DIV_STEP;
                end else if (i_status.rem_zero) begin
                    o_cmd   = CMD_FL_MUL;
                    n_state = ST_FL_ACC;
                end else begin
                    o_cmd   = CMD_FL_RDS;
                    n_state = ST_FL_PRD;
                end
            end
            ST_FL_ACC: begin
                o_cmd   = CMD_FL_ACC;
                n_state = ST_FL_DIV;
            end
            ST_FL_PRD: begin
                o_cmd   = CMD_FL_PROD;
                n_state = ST_FL_WR;
            end
            ST_FL_WR: begin
                o_cmd   = CMD_FL_WR;
                n_state = ST_FL_RD;
            end
            ST_BUILD_END: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_BUILD_END;
                    n_state = ST_IDLE;
                end
            end
            ST_Q_START: begin
                if (i_status.q_oor) begin
                    n_state = ST_Q_OOR;
                end else begin
                    o_cmd   = CMD_Q_RD;
                    n_state = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                o_cmd   = CMD_Q_CHK;
                n_state = ST_Q_FIN;
            end
            ST_Q_FIN: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_Q_FIN;
                    n_state = ST_IDLE;
                end
            end
            ST_Q_OOR: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_Q_OOR;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // An accepted item always moves the controller out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_state == ST_IDLE) |=> (r_state != ST_IDLE))
        else $error("accepted transfer did not start work");

    // The divider is stepped only while it still has bits to produce.
    a_div_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_DIV_STEP) |-> !i_status.div_done)
        else $error("divider stepped after completion");

endmodule

[design/dsst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor-sum sieve table datapath
// Factor and divisor-sum memories, loop counters, a radix-2 divider and the
// output register.
// ----------------------------------------------------------------------------
module dsst_dp import dsst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_func,
    input  logic [LIMIT_W-1:0] i_number,
    input  logic [LIMIT_W-1:0] i_table_limit,
    input  logic               i_out_stall,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [SUM_W-1:0]   o_proper_divisor_sum,
    output logic               o_is_prime,
    output logic               o_is_amicable,
    output logic               o_out_of_range,
    output logic               o_build_done
);

    logic [ADDR_W-1:0] factor_mem [TABLE_DEPTH];
    logic [SUM_W-1:0]  sum_mem    [TABLE_DEPTH];

    logic [ADDR_W-1:0]  r_fac_rd;
    logic [SUM_W-1:0]   r_sum_rd;
    logic [LIMIT_W-1:0] r_n;
    logic [ADDR_W-1:0]  r_lim;
    logic [CNT_W-1:0]   r_built;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_sq;
    logic [ADDR_W-1:0]  r_p;
    logic [ADDR_W-1:0]  r_q;
    logic [ADDR_W-1:0]  r_pk;
    logic [SUM_W-1:0]   r_sd;
    logic [SUM_W-1:0]   r_prod;
    logic [ADDR_W-1:0]  r_dnum;
    logic [ADDR_W-1:0]  r_drem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [SUM_W-1:0]   r_s;
    logic               r_prime;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_o_sum;
    logic               r_o_prime;
    logic               r_o_amic;
    logic               r_o_oor;
    logic               r_o_done;

    logic [ADDR_W-1:0] w_lim;
    logic              w_fac_we;
    logic [ADDR_W-1:0] w_fac_wa;
    logic [ADDR_W-1:0] w_fac_wd;
    logic              w_fac_re;
    logic [ADDR_W-1:0] w_fac_ra;
    logic              w_sum_we;
    logic [ADDR_W-1:0] w_sum_wa;
    logic [SUM_W-1:0]  w_sum_wd;
    logic              w_sum_re;
    logic [ADDR_W-1:0] w_sum_ra;
    logic [SUM_W-1:0]  w_s;
    logic [ADDR_W:0]   w_trial;
    logic              w_qbit;
    logic [ADDR_W-1:0] w_rem;
    logic              w_amic;
    logic              w_load;

    // Build limit, clamped to the table.
    always_comb begin
        if (32'(i_table_limit) < 2) begin
            w_lim = ADDR_W'(2);
        end else if (32'(i_table_limit) > TABLE_DEPTH - 1) begin
            w_lim = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            w_lim = ADDR_W'(i_table_limit);
        end
    end

    assign w_s = r_sum_rd - SUM_W'(r_n);

    always_comb begin
        w_fac_we = (i_cmd == CMD_CLR) || (i_cmd == CMD_SV_MARK);
        w_fac_wa = ADDR_W'(r_j);
        w_fac_wd = (i_cmd == CMD_CLR) ? '0 : ADDR_W'(r_i);
        w_fac_re = (i_cmd == CMD_SV_RD) || (i_cmd == CMD_FL_RD) || (i_cmd == CMD_Q_RD);
        w_fac_ra = (i_cmd == CMD_Q_RD) ? ADDR_W'(r_n) : ADDR_W'(r_i);
        w_sum_we = (i_cmd == CMD_FL_SMALL) || (i_cmd == CMD_FL_PRIME) || (i_cmd == CMD_FL_WR);
        w_sum_wa = ADDR_W'(r_i);
        case (i_cmd)
            CMD_FL_SMALL: w_sum_wd = SUM_W'(r_i);
            CMD_FL_PRIME: w_sum_wd = SUM_W'(r_i) + SUM_W'(1);
            default:      w_sum_wd = r_prod;
        endcase
        w_sum_re = (i_cmd == CMD_FL_RDS) || (i_cmd == CMD_Q_RD) || (i_cmd == CMD_Q_CHK);
        case (i_cmd)
            CMD_Q_RD:  w_sum_ra = ADDR_W'(r_n);
            CMD_Q_CHK: w_sum_ra = ADDR_W'(w_s);
            default:   w_sum_ra = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fac_we) begin
            factor_mem[w_fac_wa] <= w_fac_wd;
        end
        if (w_fac_re) begin
            r_fac_rd <= factor_mem[w_fac_ra];
        end
        if (w_sum_we) begin
            sum_mem[w_sum_wa] <= w_sum_wd;
        end
        if (w_sum_re) begin
            r_sum_rd <= sum_mem[w_sum_ra];
        end
    end

    // One quotient bit per step.
    always_comb begin
        w_trial = {r_drem, r_dnum[ADDR_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_p});
        w_rem   = w_qbit ? ADDR_W'(w_trial - {1'b0, r_p}) : ADDR_W'(w_trial);
    end

    assign w_amic = (r_s != SUM_W'(r_n)) && (32'(r_s) <= 32'(r_built))
                    && ((r_sum_rd - r_s) == SUM_W'(r_n));

    assign w_load = (i_cmd == CMD_BUILD_END) || (i_cmd == CMD_Q_FIN) || (i_cmd == CMD_Q_OOR);

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_ACCEPT: begin
                r_n   <= i_number;
                r_lim <= w_lim;
                r_j   <= '0;
            end
            CMD_CLR:      r_j <= r_j + CNT_W'(1);
            CMD_SV_INIT: begin
                r_i  <= CNT_W'(2);
                r_sq <= CNT_W'(4);
            end
            CMD_SV_NEXT: begin
                r_i  <= r_i + CNT_W'(1);
                r_sq <= r_sq + {r_i[CNT_W-2:0], 1'b1};
            end
            CMD_SV_JINIT: r_j <= r_sq;
            CMD_SV_MARK:  r_j <= r_j + r_i;
            CMD_FL_INIT:  r_i <= '0;
            CMD_FL_SMALL: r_i <= r_i + CNT_W'(1);
            CMD_FL_PRIME: r_i <= r_i + CNT_W'(1);
            CMD_FL_START: begin
                r_p    <= r_fac_rd;
                r_q    <= ADDR_W'(r_i);
                r_pk   <= ADDR_W'(1);
                r_sd   <= SUM_W'(1);
                r_dnum <= ADDR_W'(r_i);
                r_drem <= '0;
            end
            CMD_DIV_STEP: begin
                r_dnum <= {r_dnum[ADDR_W-2:0], w_qbit};
                r_drem <= w_rem;
            end
            CMD_FL_MUL: begin
                r_q  <= r_dnum;
                r_pk <= ADDR_W'(r_pk * r_p);
            end
            CMD_FL_ACC: begin
                r_sd   <= r_sd + SUM_W'(r_pk);
                r_dnum <= r_q;
                r_drem <= '0;
            end
            CMD_FL_PROD:  r_prod <= SUM_W'(r_sd * r_sum_rd);
            CMD_FL_WR:    r_i <= r_i + CNT_W'(1);
            CMD_Q_CHK: begin
                r_s     <= w_s;
                r_prime <= (r_n >= LIMIT_W'(2)) && (r_fac_rd == '0);
            end
            default: ;
        endcase
        case (i_cmd)
            CMD_BUILD_END: begin
                r_o_sum   <= '0;
                r_o_prime <= 1'b0;
                r_o_amic  <= 1'b0;
                r_o_oor   <= 1'b0;
                r_o_done  <= 1'b1;
            end
            CMD_Q_FIN: begin
                r_o_sum   <= r_s;
                r_o_prime <= r_prime;
                r_o_amic  <= w_amic;
                r_o_oor   <= 1'b0;
                r_o_done  <= 1'b0;
            end
            CMD_Q_OOR: begin
                r_o_sum   <= '0;
                r_o_prime <= 1'b0;
                r_o_amic  <= 1'b0;
                r_o_oor   <= 1'b1;
                r_o_done  <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built     <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_BUILD_END) begin
                r_built <= CNT_W'(r_lim);
            end
            if ((i_cmd == CMD_FL_START) || (i_cmd == CMD_FL_ACC)) begin
                r_dcnt <= DCNT_W'(ADDR_W);
            end else if (i_cmd == CMD_DIV_STEP) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.in_build  = !i_func;
        o_status.clr_last  = (r_j == CNT_W'(r_lim));
        o_status.sq_over   = (r_sq > CNT_W'(r_lim));
        o_status.fac_zero  = (r_fac_rd == '0);
        o_status.j_over    = (r_j > CNT_W'(r_lim));
        o_status.fill_over = (r_i > CNT_W'(r_lim));
        o_status.i_small   = (r_i < CNT_W'(2));
        o_status.div_done  = (r_dcnt == '0);
        o_status.rem_zero  = (r_drem == '0);
        o_status.q_oor     = (r_built == '0) || (32'(r_n) > 32'(r_built));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid          = r_out_valid;
    assign o_proper_divisor_sum = r_o_sum;
    assign o_is_prime           = r_o_prime;
    assign o_is_amicable        = r_o_amic;
    assign o_out_of_range       = r_o_oor;
    assign o_build_done         = r_o_done;

    // A new result is loaded only when the previous one has left.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten before transfer");

    // The built limit always lies inside the table.
    a_built_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_built) <= TABLE_DEPTH - 1)
        else $error("built limit beyond table");

    // Sieve marks stay within the limit of the running build.
    a_mark_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_SV_MARK) |-> (32'(r_j) <= 32'(r_lim)))
        else $error("sieve mark beyond limit");

endmodule

[tb/divisor_sum_sieve_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divisor-sum sieve table testbench
// Drives build and query transfers into the sieve block, rewrites the table
// limit between phases through the configuration port, and checks every
// result against a divisor-sum predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module divisor_sum_sieve_table_test import dsst_pkg::*; ();

    // Input function codes and register indexes.
    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic [2:0] REG_TABLE_LIMIT = 3'd0;

    localparam int SUM_MASK     = (1 << SUM_W) - 1;
    localparam int CYCLE_LIMIT  = 20000000;
    localparam int QUERY_TARGET = 1400;

    typedef struct packed {
        logic             func;
        logic [LIMIT_W-1:0] number;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0] pds;
        logic             prime;
        logic             amicable;
        logic             oor;
        logic             done;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_func = 1'b0;
    logic [LIMIT_W-1:0] i_number = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [SUM_W-1:0]   o_proper_divisor_sum;
    logic               o_is_prime;
    logic               o_is_amicable;
    logic               o_out_of_range;
    logic               o_build_done;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    divisor_sum_sieve_table i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Items waiting to be sent and answers waiting to arrive.
    t_item   pending_items[$];
    t_answer expected_answers[$];

    int  error_count = 0;
    int  cycle_count = 0;
    // When set, the sender and the receiver never idle: a burst phase.
    bit  burst_mode = 1'b0;

    // Predictor state. sigma_table holds the sum of all divisors of each n,
    // valid for 0..built_to after the last build; built_to 0 means no table.
    int  limit_reg = LIMIT_RESET;
    int  built_to = 0;
    int  sigma_table[TABLE_DEPTH];

    // Rebuild the divisor sums with an additive sieve: every d adds itself
    // to each of its multiples. This is independent of the block's factor
    // walk, which gives a real cross-check of the multiplicative fill.
    function automatic void build_sigma();
        int lim;
        lim = limit_reg;
        if (lim < 2) lim = 2;
        if (lim > TABLE_DEPTH - 1) lim = TABLE_DEPTH - 1;
        for (int n = 0; n <= lim; n++) sigma_table[n] = 0;
        for (int d = 1; d <= lim; d++)
            for (int m = d; m <= lim; m += d) sigma_table[m] += d;
        built_to = lim;
    endfunction

    function automatic int proper_sum(int n);
        return (sigma_table[n] - n) & SUM_MASK;
    endfunction

    // Work out the answer to one accepted item, updating the tables on a build.
    function automatic t_answer answer_item(t_item it);
        t_answer a;
        int n, s;
        a = '0;
        n = it.number;
        if (it.func == FUNC_BUILD) begin
            build_sigma();
            a.done = 1'b1;
        end else if (built_to == 0 || n > built_to) begin
            a.oor = 1'b1;
        end else if (n != 0) begin
            s = proper_sum(n);
            a.pds = s[SUM_W-1:0];
            // A prime's only divisors are 1 and itself.
            a.prime = (n >= 2) && (sigma_table[n] == n + 1);
            a.amicable = (s != n) && (s <= built_to) && (proper_sum(s) == n);
        end
        return a;
    endfunction

    function automatic int gap_length();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    // Driver: presents the next pending item after a random gap. The
    // prediction is made at the edge where the transfer is accepted.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                expected_answers.push_back(answer_item(t_item'{func: i_func,
                                                               number: i_number}));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                i_func <= it.func;
                i_number <= it.number;
                i_in_valid <= 1'b1;
                send_gap <= gap_length();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the result channel at random and checks each transfer
    // against the oldest expected answer.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result, sum", o_proper_divisor_sum, -1);
            end else begin
                t_answer want;
                want = expected_answers.pop_front();
                if (o_proper_divisor_sum !== want.pds)
                    report_mismatch("proper_divisor_sum", o_proper_divisor_sum, want.pds);
                if (o_is_prime !== want.prime)
                    report_mismatch("is_prime", o_is_prime, want.prime);
                if (o_is_amicable !== want.amicable)
                    report_mismatch("is_amicable", o_is_amicable, want.amicable);
                if (o_out_of_range !== want.oor)
                    report_mismatch("out_of_range", o_out_of_range, want.oor);
                if (o_build_done !== want.done)
                    report_mismatch("build_done", o_build_done, want.done);
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= gap_length();
            i_out_stall <= 1'b0;
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("divisor_sum_sieve_table_test: done, errors");
            $finish;
        end
    end

    // Wait until every item is sent and every answer has come back, then
    // let the block settle.
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access cycle.
    task automatic write_limit(int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_TABLE_LIMIT;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_reg = value & ((1 << LIMIT_W) - 1);
    endtask

    task automatic push_item(logic func, int number);
        pending_items.push_back(t_item'{func: func, number: number[LIMIT_W-1:0]});
    endtask

    // Known amicable pairs below 16384, plus one member whose partner only
    // fits a full table.
    int amicable_numbers[13] = '{220, 284, 1184, 1210, 2620, 2924, 5020, 5564, 6232, 6368,
                                 10744, 10856, 12285};

    initial begin
        int queries_sent;
        int phase_len;
        int lim;
        int r;

        queries_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A query before any build must come back out of range.
        push_item(FUNC_QUERY, 5);
        drain();

        // A limit below two builds a table up to two.
        write_limit(0);
        push_item(FUNC_BUILD, 16383);
        push_item(FUNC_QUERY, 0);
        push_item(FUNC_QUERY, 1);
        push_item(FUNC_QUERY, 2);
        push_item(FUNC_QUERY, 3);
        drain();

        // A small table: the partner of 220 lies outside it, 6 is perfect.
        write_limit(250);
        push_item(FUNC_BUILD, 0);
        push_item(FUNC_QUERY, 220);
        push_item(FUNC_QUERY, 6);
        push_item(FUNC_QUERY, 97);
        push_item(FUNC_QUERY, 250);
        push_item(FUNC_QUERY, 251);
        // The new limit has no effect until the next build.
        drain();
        write_limit(16383);
        push_item(FUNC_QUERY, 240);
        push_item(FUNC_QUERY, 300);
        push_item(FUNC_BUILD, 0);
        push_item(FUNC_QUERY, 220);
        push_item(FUNC_QUERY, 284);
        push_item(FUNC_QUERY, 8128);
        push_item(FUNC_QUERY, 12285);
        push_item(FUNC_QUERY, 14595);
        push_item(FUNC_QUERY, 16383);
        push_item(FUNC_QUERY, 16381);
        push_item(FUNC_QUERY, 0);
        burst_mode = 1'b1;
        // The full table is in place: query it widely while it is there.
        for (int k = 0; k < 200; k++) push_item(FUNC_QUERY, $urandom_range(0, 16383));
        drain();
        burst_mode = 1'b0;
        for (int k = 0; k < 200; k++) begin
            r = $urandom_range(0, 9);
            push_item(FUNC_QUERY, r < 3 ? amicable_numbers[$urandom_range(0, 12)]
                                        : $urandom_range(0, 16383));
        end
        queries_sent = 400;
        drain();

        // Random phases: rewrite the limit, build, then query the new table.
        // Most tables are small so that builds stay short.
        while (queries_sent < QUERY_TARGET) begin
            r = $urandom_range(0, 9);
            if (r == 0) lim = $urandom_range(0, 2);
            else if (r == 1) lim = $urandom_range(800, 2500);
            else lim = $urandom_range(3, 400);
            burst_mode = ($urandom_range(0, 5) == 0);
            write_limit(lim);
            push_item(FUNC_BUILD, $urandom_range(0, 16383));
            if (lim < 2) lim = 2;
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 2) push_item(FUNC_BUILD, $urandom_range(0, 16383));
                else if (r < 72) push_item(FUNC_QUERY, $urandom_range(0, lim));
                else if (r < 82) push_item(FUNC_QUERY, amicable_numbers[$urandom_range(0, 12)]);
                else push_item(FUNC_QUERY, $urandom_range(0, 16383));
            end
            queries_sent += phase_len;
            drain();
        end

        if (error_count == 0) begin
            $display("divisor_sum_sieve_table_test: done, clean");
        end else begin
            $display("divisor_sum_sieve_table_test: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
design/dsst_pkg.sv
design/dsst_ctrl.sv
design/dsst_dp.sv
design/divisor_sum_sieve_table.sv
tb/divisor_sum_sieve_table_test.sv
